// File: rtl/stp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stp_pkg;

  // width of every position field on the result ports
  localparam int unsigned OutPosW = 16;

  // entries of the queue between classifier and result stage
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // characters the scanner tests for
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharTab    = 8'h09;
  localparam logic [7:0] CharNewln  = 8'h0A;
  localparam logic [7:0] CharLparen = 8'h28;
  localparam logic [7:0] CharRparen = 8'h29;
  localparam logic [7:0] CharDot    = 8'h2E;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;

  typedef enum logic [2:0] {
    KIND_LPAREN = 3'd0,
    KIND_RPAREN = 3'd1,
    KIND_IDENT  = 3'd2,
    KIND_INT    = 3'd3,
    KIND_FLOAT  = 3'd4,
    KIND_EOF    = 3'd5
  } token_kind_e;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } item_t;

  typedef struct packed {
    token_kind_e        token_kind;
    logic [OutPosW-1:0] begin_line;
    logic [OutPosW-1:0] start_column;
    logic [OutPosW-1:0] end_line;
    logic [OutPosW-1:0] stop_column;
    logic               last_of_run;
  } token_t;

  // all the records one source item causes
  typedef struct packed {
    logic   two;
    token_t first;
    token_t second;
  } event_t;

endpackage

`default_nettype wire

// File: rtl/stp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module stp_front #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire stp_pkg::item_t item_i,
  output logic                ev_valid_o,
  output stp_pkg::event_t     ev_o
);
  import stp_pkg::*;

  localparam logic [1:0] ModeIdle   = 2'd0;
  localparam logic [1:0] ModeNumber = 2'd1;
  localparam logic [1:0] ModeIdent  = 2'd2;

  localparam int unsigned ExtW = POSITION_BITS + OutPosW;

  logic [1:0]               mode_q, mode_d;
  logic                     dot_q, dot_d;
  logic [POSITION_BITS-1:0] line_q, line_d;
  logic [POSITION_BITS-1:0] col_q, col_d;
  logic [POSITION_BITS-1:0] tsl_q, tsl_d;
  logic [POSITION_BITS-1:0] tsc_q, tsc_d;

  logic [ExtW-1:0] line_x, col_x, tsl_x, tsc_x;

  logic [1:0]  mode_eff;
  logic [7:0]  ch;
  logic        is_digit, is_dot, is_nl, is_blank, is_paren;
  logic        close, idle_go, single;
  token_kind_e word_kind, single_kind;
  token_t      word_rec, single_rec;
  logic [POSITION_BITS-1:0] line_inc, col_inc;

  assign line_x = {{OutPosW{1'b0}}, line_q};
  assign col_x  = {{OutPosW{1'b0}}, col_q};
  assign tsl_x  = {{OutPosW{1'b0}}, tsl_q};
  assign tsc_x  = {{OutPosW{1'b0}}, tsc_q};

  // saturating position increments
  assign line_inc = (line_q == '1) ? line_q : line_q + 1'b1;
  assign col_inc  = (col_q == '1) ? col_q : col_q + 1'b1;

  assign ch       = item_i.source_byte;
  assign is_digit = (ch >= CharZero) && (ch <= CharNine);
  assign is_dot   = (ch == CharDot);
  assign is_nl    = (ch == CharNewln);
  assign is_blank = (ch == CharSpace) || (ch == CharTab);
  assign is_paren = (ch == CharLparen) || (ch == CharRparen);

  always_comb begin
    unique case (mode_q)
      ModeNumber: mode_eff = ModeNumber;
      ModeIdent:  mode_eff = ModeIdent;
      default:    mode_eff = ModeIdle;
    endcase
  end

  always_comb begin
    close   = 1'b0;
    idle_go = 1'b0;
    if (item_i.end_of_source) begin
      close = (mode_eff != ModeIdle);
    end else begin
      unique case (mode_eff)
        ModeNumber: close = !(is_digit || is_dot);
        ModeIdent:  close = is_blank || is_nl || is_paren;
        default:    close = 1'b0;
      endcase
      idle_go = close || (mode_eff == ModeIdle);
    end
  end

  // record that is not a word: end of file or a paren
  assign single = item_i.end_of_source || (idle_go && is_paren);

  always_comb begin
    if (item_i.end_of_source) begin
      single_kind = KIND_EOF;
    end else if (ch == CharLparen) begin
      single_kind = KIND_LPAREN;
    end else begin
      single_kind = KIND_RPAREN;
    end
    if (mode_eff == ModeNumber) begin
      word_kind = dot_q ? KIND_FLOAT : KIND_INT;
    end else begin
      word_kind = KIND_IDENT;
    end
  end

  always_comb begin
    word_rec.token_kind   = word_kind;
    word_rec.begin_line   = tsl_x[OutPosW-1:0];
    word_rec.start_column = tsc_x[OutPosW-1:0];
    word_rec.end_line     = line_x[OutPosW-1:0];
    word_rec.stop_column  = col_x[OutPosW-1:0];
    word_rec.last_of_run  = !single;

    single_rec.token_kind   = single_kind;
    single_rec.begin_line   = line_x[OutPosW-1:0];
    single_rec.start_column = col_x[OutPosW-1:0];
    single_rec.end_line     = line_x[OutPosW-1:0];
    single_rec.stop_column  = col_x[OutPosW-1:0];
    single_rec.last_of_run  = 1'b1;
  end

  assign ev_valid_o = accept_i && (close || single);
  assign ev_o.two    = close && single;
  assign ev_o.first  = close ? word_rec : single_rec;
  assign ev_o.second = single_rec;

  // next scan state
  always_comb begin
    mode_d = mode_eff;
    dot_d  = dot_q;
    line_d = line_q;
    col_d  = col_q;
    tsl_d  = tsl_q;
    tsc_d  = tsc_q;
    if (close || item_i.end_of_source) begin
      mode_d = ModeIdle;
      dot_d  = 1'b0;
    end
    if (idle_go) begin
      if (is_nl) begin
        line_d = line_inc;
        col_d  = {{(POSITION_BITS-1){1'b0}}, 1'b1};
      end else if (is_blank || is_paren) begin
        col_d = col_inc;
      end else begin
        tsl_d  = line_q;
        tsc_d  = col_q;
        dot_d  = 1'b0;
        mode_d = is_digit ? ModeNumber : ModeIdent;
        col_d  = col_inc;
      end
    end else if (!item_i.end_of_source) begin
      // word keeps running
      if (is_dot) begin
        dot_d = 1'b1;
      end
      col_d = col_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      dot_q  <= 1'b0;
      line_q <= {{(POSITION_BITS-1){1'b0}}, 1'b1};
      col_q  <= {{(POSITION_BITS-1){1'b0}}, 1'b1};
      tsl_q  <= {{(POSITION_BITS-1){1'b0}}, 1'b1};
      tsc_q  <= {{(POSITION_BITS-1){1'b0}}, 1'b1};
    end else if (accept_i) begin
      mode_q <= mode_d;
      dot_q  <= dot_d;
      line_q <= line_d;
      col_q  <= col_d;
      tsl_q  <= tsl_d;
      tsc_q  <= tsc_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/stp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module stp_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_i,
  input  wire stp_pkg::event_t wr_data_i,
  output logic                 full_o,
  input  wire logic            rd_i,
  output logic                 rd_valid_o,
  output stp_pkg::event_t      rd_data_o
);
  import stp_pkg::*;

  event_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]  cnt_q, cnt_d;
  logic                  do_wr, do_rd;

  assign full_o     = (cnt_q == QueueCntW'(QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];

  assign do_wr = wr_i && !full_o;
  assign do_rd = rd_i && rd_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/stp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module stp_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            ev_valid_i,
  input  wire stp_pkg::event_t ev_i,
  output logic                 ev_pop_o,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output stp_pkg::token_t      token_o
);
  import stp_pkg::*;

  logic   out_valid_q, out_valid_d;
  token_t out_q, out_d;
  logic   sub_q, sub_d;   // 1: second record of the head entry is next
  logic   load;

  assign empty_o = !out_valid_q;
  assign token_o = out_q;

  assign load = ev_valid_i && (!out_valid_q || pop_i);

  always_comb begin
    out_valid_d = out_valid_q && !pop_i;
    out_d       = out_q;
    sub_d       = sub_q;
    ev_pop_o    = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      if (sub_q) begin
        out_d    = ev_i.second;
        sub_d    = 1'b0;
        ev_pop_o = 1'b1;
      end else begin
        out_d = ev_i.first;
        if (ev_i.two) begin
          sub_d = 1'b1;
        end else begin
          ev_pop_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sub_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sub_q       <= sub_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/s_expression_tokenizer.sv
// S-expression tokenizer: turns a stream of source bytes into token words.
// Input side is a queue write port: a word (source_byte, end_of_source) is
// taken on a rising edge with push high and full low. Result side is a queue
// read port: while empty is low the oldest token word is on token_o, and it
// is taken on a rising edge with pop high.
// Each input word gives zero, one or two token words; last_of_run marks the
// final one of its run. Whitespace and word characters give nothing unless
// they close an open word. The classifier takes one input word per cycle
// while full is low and turns it into all its records in the cycle it is
// taken; the result stage hands out one token word per cycle while pop is
// high. Each token passes classifier -> queue -> output register before it
// shows on token_o.
// A two-entry event queue sits between classifier and result stage; when the
// receiver stalls (pop low) it fills and full rises, and no input is lost.
// Reset (async, active low) empties queue and output, puts the scanner
// between tokens at line 1, column 1. Positions saturate at their maximum.
`timescale 1ns / 1ps
`default_nettype none

module s_expression_tokenizer #(
  parameter int unsigned POSITION_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire stp_pkg::item_t item_i,
  output logic                empty,
  input  wire logic           pop,
  output stp_pkg::token_t     token_o
);
  import stp_pkg::*;

  logic   accept;
  logic   ev_valid, q_full;
  event_t ev, q_head;
  logic   q_valid, q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  // front: scan state and token classification
  stp_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .item_i    (item_i),
    .ev_valid_o(ev_valid),
    .ev_o      (ev)
  );

  // decoupling queue; input words that make no token never enter it
  stp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (ev_valid),
    .wr_data_i (ev),
    .full_o    (q_full),
    .rd_i      (q_pop),
    .rd_valid_o(q_valid),
    .rd_data_o (q_head)
  );

  // back: splits events into token words behind an output register
  stp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ev_valid_i(q_valid),
    .ev_i      (q_head),
    .ev_pop_o  (q_pop),
    .empty_o   (empty),
    .pop_i     (pop),
    .token_o   (token_o)
  );

  // the second word of a run is already queued when the first one leaves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !token_o.last_of_run) |=> !empty)
    else $error("second token of a run missing");

  // parens are points: stop equals start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (token_o.token_kind == KIND_LPAREN || token_o.token_kind == KIND_RPAREN))
    |-> (token_o.end_line == token_o.begin_line &&
         token_o.stop_column == token_o.start_column))
    else $error("paren token with differing start and stop");

  // end of file always closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && token_o.token_kind == KIND_EOF) |-> token_o.last_of_run)
    else $error("end-of-file token not last of run");

endmodule

`default_nettype wire

// File: tb/sv/s_expression_tokenizer_test.sv
`timescale 1ns / 1ps

module s_expression_tokenizer_test;
  import stp_pkg::*;

  // random source words after the directed rows
  localparam int unsigned RandomWords = 1500;
  localparam logic [OutPosW-1:0] PosMax = '1;
  localparam logic [OutPosW-1:0] PosOne = {{(OutPosW-1){1'b0}}, 1'b1};
  localparam logic [7:0] LowerA = 8'h61;

  // scanner phase as the tokenizer tracks it
  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_NUMBER,
    SCAN_IDENT
  } scan_mode_e;

  // one row of the directed table; tok is used only when typed is set
  typedef struct {
    item_t  word;
    logic   typed;
    token_t tok;
  } source_row_t;

  logic   clk_i;
  logic   rst_ni = 1'b0;
  logic   push = 1'b0;
  logic   full;
  item_t  item_i = '0;
  logic   empty;
  logic   pop = 1'b0;
  token_t token_o;

  s_expression_tokenizer dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .item_i  (item_i),
    .empty   (empty),
    .pop     (pop),
    .token_o (token_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Token predictor: scanner state mirrored from reset, one call per word
  // taken by the block. Tokens of the word land in scan_out[0 .. scan_cnt-1].
  // ---------------------------------------------------------------------------
  scan_mode_e         scan_mode = SCAN_IDLE;
  logic               seen_dot = 1'b0;
  logic [OutPosW-1:0] cur_line = PosOne;
  logic [OutPosW-1:0] cur_col = PosOne;
  logic [OutPosW-1:0] tok_line = PosOne;
  logic [OutPosW-1:0] tok_col = PosOne;
  token_t             scan_out [2];
  int                 scan_cnt;

  // tokens predicted but not yet popped, oldest first
  token_t pending_tokens [$];

  int  sent_words = 0;
  int  two_runs = 0;
  int  tokens_seen = 0;
  int  fail_count = 0;
  // set for stretches with no idling on either side
  bit  steady = 1'b0;

  // positions stick at their maximum
  function automatic logic [OutPosW-1:0] bump(logic [OutPosW-1:0] v);
    return (v == PosMax) ? v : v + 1'b1;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= CharZero && b <= CharNine;
  endfunction

  // whitespace or paren: terminates an identifier
  function automatic logic ends_ident(logic [7:0] b);
    return b inside {CharSpace, CharTab, CharNewln, CharLparen, CharRparen};
  endfunction

  function automatic void emit(token_kind_e k, logic [OutPosW-1:0] sl, sc, el, ec);
    scan_out[scan_cnt] = '{token_kind: k, begin_line: sl, start_column: sc,
                           end_line: el, stop_column: ec, last_of_run: 1'b0};
    scan_cnt++;
  endfunction

  // word is done: number kind hinges on whether a dot showed up
  function automatic void close_word();
    token_kind_e k;
    if (scan_mode != SCAN_NUMBER) k = KIND_IDENT;
    else if (seen_dot) k = KIND_FLOAT;
    else k = KIND_INT;
    emit(k, tok_line, tok_col, cur_line, cur_col);
    scan_mode = SCAN_IDLE;
    seen_dot = 1'b0;
  endfunction

  function automatic void between_tokens(logic [7:0] b);
    if (b == CharNewln) begin
      cur_line = bump(cur_line);
      cur_col = PosOne;
    end else if (b == CharSpace || b == CharTab) begin
      cur_col = bump(cur_col);
    end else if (b == CharLparen || b == CharRparen) begin
      if (b == CharLparen) emit(KIND_LPAREN, cur_line, cur_col, cur_line, cur_col);
      else emit(KIND_RPAREN, cur_line, cur_col, cur_line, cur_col);
      cur_col = bump(cur_col);
    end else begin
      // anything else opens a word; a digit makes it a number
      tok_line = cur_line;
      tok_col = cur_col;
      seen_dot = 1'b0;
      if (is_digit(b)) scan_mode = SCAN_NUMBER;
      else scan_mode = SCAN_IDENT;
      cur_col = bump(cur_col);
    end
  endfunction

  function automatic int scan_word(item_t w);
    logic [7:0] b;
    b = w.source_byte;
    scan_cnt = 0;
    if (w.end_of_source) begin
      // an open word stops right here, then the end-of-file token
      if (scan_mode != SCAN_IDLE) close_word();
      emit(KIND_EOF, cur_line, cur_col, cur_line, cur_col);
    end else if (scan_mode == SCAN_NUMBER) begin
      if (is_digit(b) || b == CharDot) begin
        if (b == CharDot) seen_dot = 1'b1;
        cur_col = bump(cur_col);
      end else begin
        close_word();
        between_tokens(b);
      end
    end else if (scan_mode == SCAN_IDENT) begin
      if (ends_ident(b)) begin
        close_word();
        between_tokens(b);
      end else begin
        cur_col = bump(cur_col);
      end
    end else begin
      between_tokens(b);
    end
    if (scan_cnt > 0) scan_out[scan_cnt-1].last_of_run = 1'b1;
    return scan_cnt;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly none, some short, a few long.
  // ---------------------------------------------------------------------------
  function automatic int idle_cycles();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: inputs change on the falling edge, a word is taken on the rising
  // edge with push high and full low. The predictor runs at that edge; a
  // typed row supplies its single token by hand instead.
  // ---------------------------------------------------------------------------
  task automatic send_word(item_t w, logic typed = 1'b0, token_t typed_tok = '0);
    int gap;
    int n;
    gap = idle_cycles();
    repeat (gap) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push <= 1'b1;
    item_i <= w;
    do @(posedge clk_i); while (full);
    n = scan_word(w);
    sent_words++;
    if (n == 2) two_runs++;
    if (typed) pending_tokens.insert(pending_tokens.size(), typed_tok);
    else for (int i = 0; i < n; i++) pending_tokens.insert(pending_tokens.size(), scan_out[i]);
  endtask

  // body character of an identifier: letters, digits, dots, odd bytes
  function automatic logic [7:0] ident_char();
    logic [7:0] b;
    case ($urandom_range(0, 3))
      0: b = LowerA + 8'($urandom_range(0, 25));
      1: b = CharZero + 8'($urandom_range(0, 9));
      2: b = CharDot;
      default: begin
        do b = 8'($urandom_range(0, 255)); while (ends_ident(b));
      end
    endcase
    return b;
  endfunction

  // One random lexical piece. Pieces are glued with no forced separator, so
  // a number running into a letter or a paren closing a word comes up often.
  task automatic send_chunk();
    int r;
    int len;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 22) begin
      // number: digit first, then digits and the odd dot
      send_word('{CharZero + 8'($urandom_range(0, 9)), 1'b0});
      len = $urandom_range(0, 5);
      repeat (len) begin
        if ($urandom_range(0, 5) == 0) b = CharDot;
        else b = CharZero + 8'($urandom_range(0, 9));
        send_word('{b, 1'b0});
      end
    end else if (r < 44) begin
      do b = ident_char(); while (is_digit(b));
      send_word('{b, 1'b0});
      len = $urandom_range(0, 5);
      repeat (len) send_word('{ident_char(), 1'b0});
    end else if (r < 64) begin
      len = $urandom_range(1, 3);
      repeat (len) begin
        case ($urandom_range(0, 2))
          0: b = CharSpace;
          1: b = CharTab;
          default: b = CharNewln;
        endcase
        send_word('{b, 1'b0});
      end
    end else if (r < 82) begin
      send_word('{$urandom_range(0, 1) ? CharLparen : CharRparen, 1'b0});
    end else if (r < 97) begin
      send_word('{8'($urandom_range(0, 255)), 1'b0});
    end else begin
      // end of source, byte field carries junk
      send_word('{8'($urandom_range(0, 255)), 1'b1});
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: pop changes on the falling edge, stalls of random length.
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      pop <= 1'b1;
      stall_left <= idle_cycles();
    end
  end

  // every popped token word against the oldest prediction
  always @(posedge clk_i) begin : check_tokens
    token_t want;
    if (rst_ni && pop && !empty) begin
      tokens_seen++;
      if (pending_tokens.size() == 0) begin
        $error("token word popped with none predicted: kind %0d line %0d col %0d",
               token_o.token_kind, token_o.begin_line, token_o.start_column);
        fail_count++;
      end else begin
        want = pending_tokens.pop_front();
        if (token_o.token_kind !== want.token_kind) begin
          $error("token_kind: expected %0d, got %0d", want.token_kind, token_o.token_kind);
          fail_count++;
        end
        if (token_o.begin_line !== want.begin_line) begin
          $error("begin_line: expected %0d, got %0d", want.begin_line, token_o.begin_line);
          fail_count++;
        end
        if (token_o.start_column !== want.start_column) begin
          $error("start_column: expected %0d, got %0d",
                 want.start_column, token_o.start_column);
          fail_count++;
        end
        if (token_o.end_line !== want.end_line) begin
          $error("end_line: expected %0d, got %0d", want.end_line, token_o.end_line);
          fail_count++;
        end
        if (token_o.stop_column !== want.stop_column) begin
          $error("stop_column: expected %0d, got %0d",
                 want.stop_column, token_o.stop_column);
          fail_count++;
        end
        if (token_o.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0d, got %0d",
                 want.last_of_run, token_o.last_of_run);
          fail_count++;
        end
      end
    end
  end

  // directed row; typed rows give exactly one token, always last of its run
  function automatic source_row_t row(logic [7:0] b, logic eos = 1'b0,
                                      logic typed = 1'b0, token_kind_e k = KIND_EOF,
                                      int sl = 1, int sc = 1, int el = 1, int ec = 1);
    source_row_t r;
    r.word = '{b, eos};
    r.typed = typed;
    r.tok = '{k, OutPosW'(sl), OutPosW'(sc), OutPosW'(el), OutPosW'(ec), 1'b1};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: directed table, random pieces, a short random tail and a
  // closing end of source.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    source_row_t directed [$];
    int          base;

    // parens from reset
    directed.insert(directed.size(), row(CharLparen, 1'b0, 1'b1, KIND_LPAREN, 1, 1, 1, 1));
    directed.insert(directed.size(), row(CharRparen, 1'b0, 1'b1, KIND_RPAREN, 1, 2, 1, 2));
    // "0.9" ended by a letter: float, then identifier from the letter
    directed.insert(directed.size(), row(CharZero));
    directed.insert(directed.size(), row(CharDot));
    directed.insert(directed.size(), row(CharNine));
    directed.insert(directed.size(), row(LowerA, 1'b0, 1'b1, KIND_FLOAT, 1, 3, 1, 6));
    // zero byte and 0xff inside an identifier, tab ends it
    directed.insert(directed.size(), row(8'h00));
    directed.insert(directed.size(), row(8'hFF));
    directed.insert(directed.size(), row(CharTab, 1'b0, 1'b1, KIND_IDENT, 1, 6, 1, 9));
    // zero byte ends a number and opens an identifier
    directed.insert(directed.size(), row(CharNine));
    directed.insert(directed.size(), row(8'h00, 1'b0, 1'b1, KIND_INT, 1, 10, 1, 11));
    // paren closing a word: two tokens
    directed.insert(directed.size(), row(CharLparen));
    directed.insert(directed.size(), row(CharNewln));
    directed.insert(directed.size(), row(CharSpace));
    directed.insert(directed.size(), row(8'h35));
    directed.insert(directed.size(), row(CharRparen));
    // end of source between tokens, twice: same position both times
    directed.insert(directed.size(), row(8'h00, 1'b1, 1'b1, KIND_EOF, 2, 4, 2, 4));
    directed.insert(directed.size(), row(8'hFF, 1'b1, 1'b1, KIND_EOF, 2, 4, 2, 4));
    directed.insert(directed.size(), row(8'h71));
    directed.insert(directed.size(), row(CharNewln, 1'b0, 1'b1, KIND_IDENT, 2, 4, 2, 5));
    // end of source with a number open, then with an identifier open
    directed.insert(directed.size(), row(8'h31));
    directed.insert(directed.size(), row(8'h31, 1'b1));
    directed.insert(directed.size(), row(CharDot));
    directed.insert(directed.size(), row(CharLparen, 1'b1));
    directed.insert(directed.size(), row(CharRparen, 1'b0, 1'b1, KIND_RPAREN, 3, 3, 3, 3));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send_word(directed[i].word, directed[i].typed, directed[i].tok);

    base = sent_words;
    while (sent_words < base + RandomWords) begin
      if ($urandom_range(0, 59) == 0) steady = !steady;
      send_chunk();
    end

    steady = 1'b0;
    repeat (40) send_chunk();
    send_word('{8'h00, 1'b1});

    @(negedge clk_i);
    push <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
    // keep the clock running so a stray extra token would still be caught
    repeat (20) @(posedge clk_i);

    $display("Covered %0d source words, %0d token words checked (%0d words gave two),",
             sent_words, tokens_seen, two_runs);
    $display("including words cut by parens and end of source, and repeated end of source.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit: well above the slowest legal run
  initial begin
    #(50_000_000);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
rtl/stp_pkg.sv
rtl/stp_front.sv
rtl/stp_queue.sv
rtl/stp_back.sv
rtl/s_expression_tokenizer.sv
tb/sv/s_expression_tokenizer_test.sv
